/* design/shs_pkg.sv */
// shs_pkg: shared types and constants for the streaming superfasthash block
// holds the queue entry passed from the front end to the hash back end
// no dependencies
`default_nettype none

package shs_pkg;

    localparam int HASH_W      = 32;
    localparam int CFG_W       = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FULL,
        OP_TAIL1,
        OP_TAIL2,
        OP_TAIL3
    } t_op;

    typedef struct packed {
        logic [HASH_W-1:0] word;
        logic [HASH_W-1:0] seed;
        t_op               op;
        logic              first;
        logic              last;
        logic              len_zero;
        logic              len_err;
    } t_entry;

endpackage

`default_nettype wire

/* design/shs_front.sv */
// shs_front: accepts message words, tracks byte count and classifies each word
// holds the length register; uses shs_pkg for the entry type
`default_nettype none

module shs_front #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [shs_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                      i_valid,
    input  wire logic [shs_pkg::HASH_W-1:0] i_word,
    input  wire logic                      i_last,
    input  wire logic                      i_push_ready,
    output shs_pkg::t_entry                o_entry,
    output logic                           o_push
);

    logic [LENGTH_BITS-1:0] r_len;
    logic [LENGTH_BITS-1:0] r_cons;
    logic                   r_active;
    logic                   r_err;

    logic [LENGTH_BITS-1:0] n_cons;
    logic                   n_err;
    logic [LENGTH_BITS-1:0] cons;
    logic [LENGTH_BITS:0]   diff;
    logic [shs_pkg::HASH_W-1:0] cfg_ext;
    logic                   first;
    logic                   len_zero;
    shs_pkg::t_op           op;

    assign o_push  = i_valid && i_push_ready;
    assign cfg_ext = shs_pkg::HASH_W'(i_cfg_wdata);

    always_comb begin
        first    = !r_active;
        cons     = first ? '0 : r_cons;
        len_zero = (r_len == '0);
        diff     = {1'b0, r_len} - {1'b0, cons};
        n_cons   = cons;
        n_err    = first ? 1'b0 : r_err;
        if (diff[LENGTH_BITS] || diff == '0) begin
            op = shs_pkg::OP_NONE;
            if (!(first && len_zero)) begin
                n_err = 1'b1;
            end
        end else if (|diff[LENGTH_BITS-1:2]) begin
            op     = shs_pkg::OP_FULL;
            n_cons = cons + LENGTH_BITS'(4);
        end else begin
            unique case (diff[1:0])
                2'd1:    op = shs_pkg::OP_TAIL1;
                2'd2:    op = shs_pkg::OP_TAIL2;
                default: op = shs_pkg::OP_TAIL3;
            endcase
            n_cons = r_len;
        end

        o_entry.word     = i_word;
        o_entry.seed     = shs_pkg::HASH_W'(r_len);
        o_entry.op       = op;
        o_entry.first    = first;
        o_entry.last     = i_last;
        o_entry.len_zero = len_zero;
        o_entry.len_err  = n_err || (n_cons != r_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_cons   <= '0;
            r_active <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= cfg_ext[LENGTH_BITS-1:0];
            end
            if (o_push) begin
                if (i_last) begin
                    r_active <= 1'b0;
                    r_cons   <= '0;
                    r_err    <= 1'b0;
                end else begin
                    r_active <= 1'b1;
                    r_cons   <= n_cons;
                    r_err    <= n_err;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* design/shs_queue.sv */
// shs_queue: short register queue between the front end and the hash back end
// uses shs_pkg for the entry type and queue depth
`default_nettype none

module shs_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire shs_pkg::t_entry i_entry,
    output logic           o_push_ready,
    input  wire logic      i_pop,
    output logic           o_pop_valid,
    output shs_pkg::t_entry o_entry
);

    shs_pkg::t_entry                 r_mem [shs_pkg::QUEUE_DEPTH];
    logic [shs_pkg::QUEUE_PTR_W-1:0] r_wptr;
    logic [shs_pkg::QUEUE_PTR_W-1:0] r_rptr;
    logic [shs_pkg::QUEUE_CNT_W-1:0] r_count;

    assign o_push_ready = (r_count != shs_pkg::QUEUE_CNT_W'(shs_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_entry      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + shs_pkg::QUEUE_CNT_W'(1);
                2'b01:   r_count <= r_count - shs_pkg::QUEUE_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/shs_back.sv */
// shs_back: running hash update per word, then avalanche finish into the output register
// uses shs_pkg for the entry type and op codes
`default_nettype none

module shs_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire shs_pkg::t_entry            i_entry,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [shs_pkg::HASH_W-1:0]      o_hash,
    output logic                            o_err
);

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [31:0] mix_full(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] a;
        logic [31:0] t;
        a = h + {16'd0, w[15:0]};
        t = {w[31:16], 11'd0} ^ a;
        a = {a[15:0], 16'd0} ^ t;
        return a + (a >> 11);
    endfunction

    function automatic logic [31:0] mix_tail(input logic [31:0] h, input logic [31:0] w,
                                             input shs_pkg::t_op op);
        logic [31:0] a;
        a = h;
        unique case (op)
            shs_pkg::OP_TAIL3: begin
                a = a + {16'd0, w[15:0]};
                a = a ^ (a << 16);
                a = a ^ (sext8(w[23:16]) << 18);
                a = a + (a >> 11);
            end
            shs_pkg::OP_TAIL2: begin
                a = a + {16'd0, w[15:0]};
                a = a ^ (a << 11);
                a = a + (a >> 17);
            end
            shs_pkg::OP_TAIL1: begin
                a = a + sext8(w[7:0]);
                a = a ^ (a << 10);
                a = a + (a >> 1);
            end
            default: a = h;
        endcase
        return a;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] a;
        a = h ^ (h << 3);
        a = a + (a >> 5);
        a = a ^ (a << 4);
        a = a + (a >> 17);
        a = a ^ (a << 25);
        return a + (a >> 6);
    endfunction

    logic [shs_pkg::HASH_W-1:0] r_hash;
    logic                       r_fin_valid;
    logic [shs_pkg::HASH_W-1:0] r_fin_hash;
    logic                       r_fin_zero;
    logic                       r_fin_err;
    logic                       r_out_valid;
    logic [shs_pkg::HASH_W-1:0] r_out_hash;
    logic                       r_out_err;

    logic [shs_pkg::HASH_W-1:0] h_in;
    logic [shs_pkg::HASH_W-1:0] n_hash;
    logic                       out_load;
    logic                       fin_free;

    assign out_load = !r_out_valid || i_ready;
    assign fin_free = !r_fin_valid || out_load;
    assign o_pop    = i_valid && (!i_entry.last || fin_free);
    assign o_valid  = r_out_valid;
    assign o_hash   = r_out_hash;
    assign o_err    = r_out_err;

    always_comb begin
        h_in = i_entry.first ? i_entry.seed : r_hash;
        if (i_entry.op == shs_pkg::OP_FULL) begin
            n_hash = mix_full(h_in, i_entry.word);
        end else begin
            n_hash = mix_tail(h_in, i_entry.word, i_entry.op);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hash <= n_hash;
        end
        if (o_pop && i_entry.last) begin
            r_fin_hash <= n_hash;
            r_fin_zero <= i_entry.len_zero;
            r_fin_err  <= i_entry.len_err;
        end
        if (out_load && r_fin_valid) begin
            r_out_hash <= r_fin_zero ? '0 : avalanche(r_fin_hash);
            r_out_err  <= r_fin_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= r_fin_valid;
            end
            if (o_pop && i_entry.last) begin
                r_fin_valid <= 1'b1;
            end else if (out_load) begin
                r_fin_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* design/superfast_hash_stream.sv */
// superfast_hash_stream: 32-bit superfasthash over a stream of little-endian words
// top level; instantiates shs_front, shs_queue and shs_back, uses shs_pkg
//
// Write the message length in bytes through i_cfg_we / i_cfg_wdata before the
// first word; it is also the hash seed. The block takes one 32-bit word per
// cycle while the queue has room, with the byte-count subtract and compare in
// the front end and the running hash update in the back end. The tlast word
// produces one result (hash in tdata, length error flag in tuser) through the
// queue entry, the hash update into the finish register, then the avalanche
// output register. A two-entry queue lets input and output stall independently.
`default_nettype none

module superfast_hash_stream #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [23:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // data_word
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // hash_value
    output logic [0:0]       m_axis_tuser    // length_error
);

    shs_pkg::t_entry push_entry;
    shs_pkg::t_entry pop_entry;
    logic            push;
    logic            push_ready;
    logic            pop;
    logic            pop_valid;
    logic            out_err;

    assign s_axis_tready   = push_ready;
    assign m_axis_tuser[0] = out_err;

    shs_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (s_axis_tvalid),
        .i_word       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_push_ready (push_ready),
        .o_entry      (push_entry),
        .o_push       (push)
    );

    shs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (push_entry),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_pop_valid  (pop_valid),
        .o_entry      (pop_entry)
    );

    shs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop_valid),
        .i_entry (pop_entry),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_hash  (m_axis_tdata),
        .o_err   (out_err)
    );

endmodule

`default_nettype wire

/* tb/shs_hash_checker.sv */
`timescale 1ns / 100ps
// shs_hash_checker: scoreboard for superfast_hash_stream; follows length writes and accepted
// words, predicts each finished hash and length flag, compares them with the result stream
// depends on shs_pkg for the hash and length widths
module shs_hash_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [shs_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [shs_pkg::HASH_W-1:0] i_s_tdata,
    input  logic                       i_s_tlast,
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [shs_pkg::HASH_W-1:0] i_m_tdata,
    input  logic [0:0]                 i_m_tuser,
    output int unsigned                o_fail_count,
    output int unsigned                o_pending
);

    localparam int HW = shs_pkg::HASH_W;
    localparam int LW = shs_pkg::CFG_W;

    typedef struct packed {
        logic [HW-1:0] hash;
        logic          len_err;
    } digest_t;

    logic [HW-1:0] run_hash;
    int unsigned   byte_count;
    logic          overrun;
    logic          in_msg;
    logic [LW-1:0] msg_len;
    digest_t       expected_digests[$];
    digest_t       want;
    int unsigned   fail_count;

    function automatic logic [HW-1:0] sext_byte(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [HW-1:0] mix_word(input logic [HW-1:0] h, input logic [HW-1:0] w);
        logic [HW-1:0] t;
        h = h + {16'h0, w[15:0]};
        t = ({16'h0, w[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [HW-1:0] mix_tail(input logic [HW-1:0] h, input logic [HW-1:0] w,
                                                input int unsigned n);
        case (n)
            3: begin
                h = h + {16'h0, w[15:0]};
                h = h ^ (h << 16);
                h = h ^ (sext_byte(w[23:16]) << 18);
                h = h + (h >> 11);
            end
            2: begin
                h = h + {16'h0, w[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            1: begin
                h = h + sext_byte(w[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: ;
        endcase
        return h;
    endfunction

    function automatic logic [HW-1:0] avalanche_hash(input logic [HW-1:0] h);
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    task automatic absorb_word(input logic [HW-1:0] w, input logic lst);
        int unsigned left;
        logic        starting;
        digest_t     d;
        starting = !in_msg;
        if (starting) begin
            run_hash   = {{(HW-LW){1'b0}}, msg_len};
            byte_count = 0;
            overrun    = 1'b0;
            in_msg     = 1'b1;
        end
        left = (byte_count < msg_len) ? msg_len - byte_count : 0;
        if (left >= 4) begin
            run_hash   = mix_word(run_hash, w);
            byte_count = byte_count + 4;
        end else if (left > 0) begin
            run_hash   = mix_tail(run_hash, w, left);
            byte_count = byte_count + left;
        end else if (!(starting && msg_len == 0)) begin
            overrun = 1'b1;
        end
        if (lst) begin
            d.hash    = (msg_len == 0) ? '0 : avalanche_hash(run_hash);
            d.len_err = overrun || (byte_count != msg_len);
            expected_digests.push_back(d);
            run_hash   = '0;
            byte_count = 0;
            overrun    = 1'b0;
            in_msg     = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_hash   = '0;
            byte_count = 0;
            overrun    = 1'b0;
            in_msg     = 1'b0;
            msg_len    = '0;
            fail_count = 0;
            expected_digests.delete();
        end else begin
            if (i_cfg_we) begin
                msg_len = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                absorb_word(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_digests.size() == 0) begin
                    $error("unexpected hash result %h, length_error %b", i_m_tdata, i_m_tuser);
                    fail_count++;
                end else begin
                    want = expected_digests.pop_front();
                    if (i_m_tdata !== want.hash) begin
                        $error("hash_value: expected %h, actual %h", want.hash, i_m_tdata);
                        fail_count++;
                    end
                    if (i_m_tuser[0] !== want.len_err) begin
                        $error("length_error: expected %b, actual %b", want.len_err, i_m_tuser);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_digests.size();
    end

endmodule

/* tb/tb_superfast_hash_stream.sv */
`timescale 1ns / 100ps
// tb_superfast_hash_stream: stimulus and verdict for superfast_hash_stream
// drives length writes and message words with random gaps and stalls; uses shs_hash_checker
module tb_superfast_hash_stream;

    localparam int unsigned LIMIT = 400000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [23:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // data_word
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // hash_value
    logic [0:0]  m_axis_tuser;          // length_error

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;
    int unsigned src_max     = 10;
    int unsigned sink_max    = 10;
    int unsigned sink_draw;
    int unsigned stall_left  = 0;
    int unsigned word_count  = 0;

    always #4 i_clk = ~i_clk;

    superfast_hash_stream u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    shs_hash_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("** superfast_hash_stream: FAILED **");
            $finish;
        end
    end

    // result side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            sink_draw = $urandom_range(0, sink_max);
            stall_left    <= sink_draw;
            m_axis_tready <= (sink_draw == 0);
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end
    end

    task automatic send_word(input logic [31:0] w, input logic lst);
        int unsigned gap;
        gap = $urandom_range(0, src_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        word_count++;
    endtask

    task automatic send_message(input int unsigned nwords);
        for (int unsigned i = 0; i < nwords; i++) begin
            send_word($urandom, i == nwords - 1);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_length(input int unsigned len);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len[23:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int unsigned len;
        int unsigned full;
        int unsigned nwords;
        int unsigned kind;
        int unsigned cls;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // length zero from reset, data ignored
        send_word(32'hFFFF_FFFF, 1'b1);
        load_length(0);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        // one, two, three tail bytes with negative bytes, then four and seven bytes
        load_length(1);
        send_word(32'hFFFF_FF80, 1'b1);
        load_length(2);
        send_word(32'h5A5A_FFFF, 1'b1);
        load_length(3);
        send_word(32'hA5FF_8000, 1'b1);
        load_length(4);
        send_word(32'hFFFF_FFFF, 1'b1);
        load_length(7);
        send_word(32'h8000_8000, 1'b0);
        send_word(32'h0080_7F7F, 1'b1);
        // last too early
        load_length(8);
        send_word(32'hDEAD_BEEF, 1'b1);
        load_length(24'hFF_FFFF);
        send_word(32'h0123_4567, 1'b0);
        send_word(32'h89AB_CDEF, 1'b1);
        // words past the end
        load_length(5);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'hFFFF_FF81, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        load_length(4);
        send_word(32'h0000_0000, 1'b1);

        word_count = 0;
        while (word_count < 1900) begin
            cls = $urandom_range(0, 9);
            if (cls < 5)
                len = $urandom_range(0, 16);
            else if (cls < 8)
                len = $urandom_range(17, 128);
            else if (cls == 8)
                len = $urandom_range(129, 512);
            else
                len = $urandom & 32'h00FF_FFFF;
            load_length(len);
            src_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
            sink_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            repeat ($urandom_range(1, 3)) begin
                full = (len == 0) ? 1 : (len + 3) / 4;
                kind = $urandom_range(0, 9);
                if (cls == 9)
                    nwords = $urandom_range(1, 5);
                else if (kind == 0 && full >= 2)
                    nwords = $urandom_range(1, (full - 1 < 6) ? full - 1 : 6);
                else if (kind == 1)
                    nwords = full + $urandom_range(1, 3);
                else
                    nwords = full;
                send_message(nwords);
                if (kind == 2)
                    drain();
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("** superfast_hash_stream: PASSED **");
        else
            $display("** superfast_hash_stream: FAILED **");
        $finish;
    end

endmodule
